>>> sv/rd_pkg.sv
`default_nettype none

package rd_pkg;

  localparam int MAX_DROPS_DEF = 16;

  // divider and square root widths
  localparam int DIV_W    = 48;
  localparam int DVS_W    = 17;
  localparam int STEP_W   = 6;
  localparam int SQ_W     = 34;
  localparam int ROOT_W   = 17;
  localparam int R_STEPS  = ROOT_W + 16;

  // register indexes
  localparam logic [2:0] CFG_AMPLITUDE  = 3'd0;
  localparam logic [2:0] CFG_WAVELENGTH = 3'd1;
  localparam logic [2:0] CFG_FREQUENCY  = 3'd2;
  localparam logic [2:0] CFG_DECAY_DIST = 3'd3;
  localparam logic [2:0] CFG_DECAY_TIME = 3'd4;
  localparam logic [2:0] CFG_MAX_DROPS  = 3'd5;

  // opcodes
  localparam logic OP_ADD_DROP = 1'b0;
  localparam logic OP_DISPLACE = 1'b1;

  // sine and exp polynomial coefficients
  localparam logic [16:0] SIN_A     = 17'd51472;
  localparam logic [16:0] SIN_B     = 17'd21024;
  localparam logic [16:0] SIN_C     = 17'd2320;
  localparam logic [16:0] EXP_K1    = 17'd45416;
  localparam logic [16:0] EXP_K2    = 17'd15538;
  localparam logic [16:0] EXP_K3    = 17'd2890;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // smallest u whose exponent integer part reaches 17 (result is zero)
  localparam longint unsigned EXP_U_LIMIT =
    ((64'd17 << 32) + 64'd94548 - 64'd1) / 64'd94548;

  localparam int POS_LIMIT = 524287;
  localparam int NEG_LIMIT = 524288;

  typedef struct packed {
    logic        opcode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] time_now;
    logic [15:0] strength;
  } in_t;

  typedef struct packed {
    logic signed [19:0] disp_x;
    logic signed [19:0] disp_y;
    logic [4:0]         drops_held;
    logic               clipped;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef logic [16:0] smooth_tbl_t [256];

  function automatic smooth_tbl_t smooth_tbl_init();
    smooth_tbl_t     tbl;
    longint unsigned s;
    for (int t = 0; t < 256; t++) begin
      s = (t >= 205) ? 64'd65536 : 64'(t) * 64'd320;
      tbl[t] = 17'((s * s * (64'd196608 - 64'd2 * s)) >> 32);
    end
    return tbl;
  endfunction

  // smoothstep over the first 0.2 s, indexed by tau
  localparam smooth_tbl_t SMOOTH_TBL = smooth_tbl_init();

endpackage

`default_nettype wire

>>> sv/rd_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle; dividend arrives MSB aligned
module rd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rd_pkg::div_req_t            req_i,
  output logic                        done_o,
  output logic [rd_pkg::DIV_W-1:0]    quot_o
);

  logic [rd_pkg::DIV_W-1:0]  q_q, q_d;
  logic [rd_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [rd_pkg::DVS_W-1:0]  dvs_q;
  logic [rd_pkg::STEP_W-1:0] cnt_q;
  logic                      busy_q, done_q;
  logic [rd_pkg::DVS_W:0]    trial;
  logic                      ge;

  always_comb begin
    trial = {rem_q, q_q[rd_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? rd_pkg::DVS_W'(trial - {1'b0, dvs_q}) : rd_pkg::DVS_W'(trial);
    q_d   = {q_q[rd_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - rd_pkg::STEP_W'(1);
        if (cnt_q == rd_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q   <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

`default_nettype wire

>>> sv/rd_sqrt.sv
`default_nettype none

// digit-by-digit integer square root, one root bit per cycle
module rd_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rd_pkg::sqrt_req_t         req_i,
  output logic                      done_o,
  output logic [rd_pkg::ROOT_W-1:0] root_o
);

  localparam int REM_W = rd_pkg::ROOT_W + 1;
  localparam int CNT_W = $clog2(rd_pkg::ROOT_W + 1);

  logic [rd_pkg::SQ_W-1:0]   v_q;
  logic [rd_pkg::ROOT_W-1:0] root_q;
  logic [REM_W-1:0]          rem_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;
  logic [REM_W+1:0]          cur, trial;
  logic                      ge;

  always_comb begin
    cur   = {rem_q, v_q[rd_pkg::SQ_W-1 -: 2]};
    trial = (REM_W + 2)'({root_q, 2'b01});
    ge    = cur >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(rd_pkg::ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v_q    <= req_i.radicand;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      v_q    <= v_q << 2;
      root_q <= {root_q[rd_pkg::ROOT_W-2:0], ge};
      rem_q  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> sv/ripple_displacement.sv
`default_nettype none

// Damped radial ripple displacement.
// Input channel (in_valid_i/in_ready_o, in_data_i): an add-drop item stores a
// drop origin and spawn time in a ring of MAX_DROPS entries, evicting the
// oldest when the max_drops register limit is reached; a displace item sums
// the radial ripple of every landed drop at the given vertex and scales it by
// strength. Every item gives exactly one result on the output channel
// (out_valid_o/out_ready_i, out_data_o), in order.
// Config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the addressed
// register; write it only while no item is in flight.
// A displace item visits every stored drop; for each landed drop the
// shared divider and square root unit dominate, while a drop not yet landed
// is only checked and skipped; everything else runs on one shared multiplier.
// Only one item is worked on at a time; in_ready_o is high while the
// sequencer is idle, also while a finished result waits in the output
// register. A stalled receiver holds that result; the next result then waits
// in the sequencer until the output register frees up.
// Reset clears the drop count and ring pointer and loads the register
// defaults; the drop store itself is not cleared.
module ripple_displacement #(
  parameter int MAX_DROPS = rd_pkg::MAX_DROPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rd_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rd_pkg::out_t  out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int IW    = (MAX_DROPS > 1) ? $clog2(MAX_DROPS) : 1;
  localparam int CW    = $clog2(MAX_DROPS + 1);
  localparam int LW    = (CW > 5) ? CW : 5;
  localparam int SUM_W = 34 + $clog2(MAX_DROPS);
  localparam int MA_W  = SUM_W;
  localparam int MB_W  = 18;
  localparam int P_W   = MA_W + MB_W;
  localparam int MAG_W = P_W - 31;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DONE = 5'd1;
  localparam logic [4:0] ST_CHK  = 5'd2;
  localparam logic [4:0] ST_LOAD = 5'd3;
  localparam logic [4:0] ST_SQX  = 5'd4;
  localparam logic [4:0] ST_SQY  = 5'd5;
  localparam logic [4:0] ST_SQRT = 5'd6;
  localparam logic [4:0] ST_FT   = 5'd7;
  localparam logic [4:0] ST_DIVP = 5'd8;
  localparam logic [4:0] ST_SN1  = 5'd9;
  localparam logic [4:0] ST_SN2  = 5'd10;
  localparam logic [4:0] ST_SN3  = 5'd11;
  localparam logic [4:0] ST_SN4  = 5'd12;
  localparam logic [4:0] ST_DIVR = 5'd13;
  localparam logic [4:0] ST_DIVT = 5'd14;
  localparam logic [4:0] ST_E1   = 5'd15;
  localparam logic [4:0] ST_E2   = 5'd16;
  localparam logic [4:0] ST_E3   = 5'd17;
  localparam logic [4:0] ST_E4   = 5'd18;
  localparam logic [4:0] ST_SM   = 5'd19;
  localparam logic [4:0] ST_W1   = 5'd20;
  localparam logic [4:0] ST_W2   = 5'd21;
  localparam logic [4:0] ST_CX   = 5'd22;
  localparam logic [4:0] ST_CY   = 5'd23;
  localparam logic [4:0] ST_FX   = 5'd24;
  localparam logic [4:0] ST_FY   = 5'd25;

  // control state
  logic [4:0]    state_q;
  logic [CW-1:0] count_q, k_q;
  logic [IW-1:0] oldest_q;
  logic          launched_q;
  logic          out_valid_q;
  rd_pkg::out_t  out_q;

  // config registers
  logic [15:0] amp_q, wl_q, freq_q, dd_q, dt_q;
  logic [4:0]  maxd_q;

  // item and per-drop datapath
  logic [15:0]      px_q, py_q, str_q;
  logic [31:0]      now_q, tau_q;
  logic [15:0]      adx_q, ady_q;
  logic             dxn_q, dyn_q;
  logic [rd_pkg::SQ_W-1:0]   sq_q;
  logic [rd_pkg::ROOT_W-1:0] r_q;
  logic [15:0]      ft_q, x15_q, x2_q, abs_s_q, f_q;
  logic [1:0]       quad_q;
  logic [16:0]      s_q, p_q, decay_q, m_q;
  logic             neg_s_q;
  logic [48:0]      u_q;
  logic [4:0]       n_q;
  logic [31:0]      am_q, w_q;
  logic [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [19:0]      res_x_q, res_y_q;
  logic             clip_q;

  // drop store
  logic [63:0]   drop_mem [MAX_DROPS];
  logic [63:0]   rd_q;
  logic [IW-1:0] wr_slot, rd_slot;
  logic [IW+1:0] wr_sum, rd_sum;
  logic          wr_en;

  // shared units
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [P_W-1:0]  prod;
  rd_pkg::div_req_t  div_req;
  rd_pkg::sqrt_req_t sq_req;
  logic              div_done, sqrt_done, unit_done;
  logic [rd_pkg::DIV_W-1:0]  quot;
  logic [rd_pkg::ROOT_W-1:0] root;

  logic          in_acc;
  logic [4:0]    lim;
  logic          grow;
  logic [16:0]   wl_eff, dd_eff, dt_eff, rc, smooth;
  logic [15:0]   phase;
  logic [15:0]   ex, ey;
  logic [31:0]   et;
  logic [SUM_W-1:0] mag_x, mag_y, cadd;
  logic [16:0]   snv;
  logic [20:0]   sat_res;
  logic          exp_zero;

  function automatic logic [20:0] sat20(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] lmt;
    logic [19:0]      v;
    logic             c;
    lmt = neg ? MAG_W'(rd_pkg::NEG_LIMIT) : MAG_W'(rd_pkg::POS_LIMIT);
    c   = mag > lmt;
    v   = c ? lmt[19:0] : mag[19:0];
    return {c, neg ? (20'd0 - v) : v};
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign lim  = (maxd_q == 5'd0) ? 5'd1 : maxd_q;
  assign grow = (LW'(count_q) < LW'(lim)) && (LW'(count_q) < LW'(MAX_DROPS));

  // ring addressing: both sums stay below twice the depth
  always_comb begin
    wr_sum = (IW + 2)'(oldest_q) + (IW + 2)'(count_q);
    if (wr_sum >= (IW + 2)'(MAX_DROPS)) wr_sum = wr_sum - (IW + 2)'(MAX_DROPS);
    rd_sum = (IW + 2)'(oldest_q) + (IW + 2)'(k_q);
    if (rd_sum >= (IW + 2)'(MAX_DROPS)) rd_sum = rd_sum - (IW + 2)'(MAX_DROPS);
    wr_slot = IW'(wr_sum);
    rd_slot = IW'(rd_sum);
  end

  assign wr_en = in_acc && (in_data_i.opcode == rd_pkg::OP_ADD_DROP);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      drop_mem[wr_slot] <= {in_data_i.pos_x, in_data_i.pos_y, in_data_i.time_now};
    end
    rd_q <= drop_mem[rd_slot];
  end

  assign ex = rd_q[63:48];
  assign ey = rd_q[47:32];
  assign et = rd_q[31:0];

  assign wl_eff = (wl_q < 16'd16) ? 17'd16 : {1'b0, wl_q};
  assign dd_eff = (dd_q < 16'd16) ? 17'd16 : {1'b0, dd_q};
  assign dt_eff = (dt_q == 16'd0) ? 17'd1 : {1'b0, dt_q};
  assign rc     = (r_q < 17'd16) ? 17'd16 : r_q;
  assign smooth = (tau_q >= 32'd205) ? 17'h10000 : rd_pkg::SMOOTH_TBL[tau_q[7:0]];
  assign phase  = quot[15:0] - ft_q;
  assign mag_x  = sum_x_q[SUM_W-1] ? (SUM_W'(0) - sum_x_q) : sum_x_q;
  assign mag_y  = sum_y_q[SUM_W-1] ? (SUM_W'(0) - sum_y_q) : sum_y_q;
  assign cadd   = SUM_W'(quot);
  assign snv    = 17'(prod >> 15);
  assign exp_zero = u_q >= 49'(rd_pkg::EXP_U_LIMIT);
  assign sat_res  = sat20((state_q == ST_FX) ? sum_x_q[SUM_W-1] : sum_y_q[SUM_W-1],
                          MAG_W'(prod >> 31));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQX: begin mul_a = MA_W'(adx_q);    mul_b = MB_W'(adx_q); end
      ST_SQY: begin mul_a = MA_W'(ady_q);    mul_b = MB_W'(ady_q); end
      ST_FT:  begin mul_a = MA_W'(freq_q);   mul_b = tau_q[17:0]; end
      ST_SN1: begin mul_a = MA_W'(x15_q);    mul_b = MB_W'(x15_q); end
      ST_SN2: begin mul_a = MA_W'(x2_q);     mul_b = MB_W'(rd_pkg::SIN_C); end
      ST_SN3: begin mul_a = MA_W'(x2_q);     mul_b = MB_W'(s_q); end
      ST_SN4: begin mul_a = MA_W'(x15_q);    mul_b = MB_W'(s_q); end
      ST_E1:  begin mul_a = MA_W'(u_q[19:0]); mul_b = MB_W'(rd_pkg::LOG2E_Q16); end
      ST_E2:  begin mul_a = MA_W'(f_q);      mul_b = MB_W'(rd_pkg::EXP_K3); end
      ST_E3:  begin mul_a = MA_W'(f_q);      mul_b = MB_W'(p_q); end
      ST_E4:  begin mul_a = MA_W'(f_q);      mul_b = MB_W'(p_q); end
      ST_SM:  begin mul_a = MA_W'(decay_q);  mul_b = MB_W'(smooth); end
      ST_W1:  begin mul_a = MA_W'(amp_q);    mul_b = MB_W'(m_q); end
      ST_W2:  begin mul_a = MA_W'(am_q);     mul_b = MB_W'(abs_s_q); end
      ST_CX:  begin mul_a = MA_W'(w_q);      mul_b = MB_W'(adx_q); end
      ST_CY:  begin mul_a = MA_W'(w_q);      mul_b = MB_W'(ady_q); end
      ST_FX:  begin mul_a = mag_x;           mul_b = MB_W'(str_q); end
      ST_FY:  begin mul_a = mag_y;           mul_b = MB_W'(str_q); end
      default: ;
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  // unit launch
  always_comb begin
    div_req = '0;
    sq_req  = '0;
    if (!launched_q) begin
      case (state_q)
        ST_SQRT: begin
          sq_req.start    = 1'b1;
          sq_req.radicand = sq_q;
        end
        ST_DIVP: begin
          div_req.start    = 1'b1;
          div_req.dividend = {r_q, 31'd0};
          div_req.divisor  = wl_eff;
          div_req.steps    = rd_pkg::STEP_W'(rd_pkg::R_STEPS);
        end
        ST_DIVR: begin
          div_req.start    = 1'b1;
          div_req.dividend = {r_q, 31'd0};
          div_req.divisor  = dd_eff;
          div_req.steps    = rd_pkg::STEP_W'(rd_pkg::R_STEPS);
        end
        ST_DIVT: begin
          div_req.start    = 1'b1;
          div_req.dividend = {tau_q, 16'd0};
          div_req.divisor  = dt_eff;
          div_req.steps    = rd_pkg::STEP_W'(rd_pkg::DIV_W);
        end
        ST_CX, ST_CY: begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_pkg::DIV_W'(prod);
          div_req.divisor  = rc;
          div_req.steps    = rd_pkg::STEP_W'(rd_pkg::DIV_W);
        end
        default: ;
      endcase
    end
  end

  rd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  rd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .done_o (sqrt_done),
    .root_o (root)
  );

  assign unit_done = div_done || sqrt_done;

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // sequencer and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      oldest_q    <= '0;
      k_q         <= '0;
      launched_q  <= 1'b0;
      amp_q       <= 16'd192;
      wl_q        <= 16'd1024;
      freq_q      <= 16'd512;
      dd_q        <= 16'd6400;
      dt_q        <= 16'd2048;
      maxd_q      <= 5'd8;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rd_pkg::CFG_AMPLITUDE:  amp_q  <= cfg_data_i;
          rd_pkg::CFG_WAVELENGTH: wl_q   <= cfg_data_i;
          rd_pkg::CFG_FREQUENCY:  freq_q <= cfg_data_i;
          rd_pkg::CFG_DECAY_DIST: dd_q   <= cfg_data_i;
          rd_pkg::CFG_DECAY_TIME: dt_q   <= cfg_data_i;
          rd_pkg::CFG_MAX_DROPS:  maxd_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data_i.opcode == rd_pkg::OP_ADD_DROP) begin
              if (grow) begin
                count_q <= count_q + CW'(1);
              end else if (oldest_q == IW'(MAX_DROPS - 1)) begin
                oldest_q <= '0;
              end else begin
                oldest_q <= oldest_q + IW'(1);
              end
              state_q <= ST_DONE;
            end else begin
              k_q     <= '0;
              state_q <= ST_CHK;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        ST_CHK:  state_q <= (k_q == count_q) ? ST_FX : ST_LOAD;
        ST_LOAD: begin
          if (et > now_q) begin
            k_q     <= k_q + CW'(1);
            state_q <= ST_CHK;
          end else begin
            state_q <= ST_SQX;
          end
        end
        ST_SQX: state_q <= ST_SQY;
        ST_SQY: state_q <= ST_SQRT;
        ST_FT:  state_q <= ST_DIVP;
        ST_SN1: state_q <= ST_SN2;
        ST_SN2: state_q <= ST_SN3;
        ST_SN3: state_q <= ST_SN4;
        ST_SN4: state_q <= ST_DIVR;
        ST_E1:  state_q <= exp_zero ? ST_SM : ST_E2;
        ST_E2:  state_q <= ST_E3;
        ST_E3:  state_q <= ST_E4;
        ST_E4:  state_q <= ST_SM;
        ST_SM:  state_q <= ST_W1;
        ST_W1:  state_q <= ST_W2;
        ST_W2:  state_q <= ST_CX;
        ST_FX:  state_q <= ST_FY;
        ST_FY:  state_q <= ST_DONE;
        ST_SQRT, ST_DIVP, ST_DIVR, ST_DIVT, ST_CX, ST_CY: begin
          if (!launched_q) begin
            launched_q <= 1'b1;
          end else if (unit_done) begin
            launched_q <= 1'b0;
            case (state_q)
              ST_SQRT: state_q <= ST_FT;
              ST_DIVP: state_q <= ST_SN1;
              ST_DIVR: state_q <= ST_DIVT;
              ST_DIVT: state_q <= ST_E1;
              ST_CX:   state_q <= ST_CY;
              default: begin
                k_q     <= k_q + CW'(1);
                state_q <= ST_CHK;
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          px_q    <= in_data_i.pos_x;
          py_q    <= in_data_i.pos_y;
          now_q   <= in_data_i.time_now;
          str_q   <= in_data_i.strength;
          sum_x_q <= '0;
          sum_y_q <= '0;
          res_x_q <= '0;
          res_y_q <= '0;
          clip_q  <= 1'b0;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.disp_x     <= res_x_q;
          out_q.disp_y     <= res_y_q;
          out_q.drops_held <= 5'(count_q);
          out_q.clipped    <= clip_q;
        end
      end
      ST_LOAD: begin
        tau_q <= now_q - et;
        dxn_q <= px_q < ex;
        dyn_q <= py_q < ey;
        adx_q <= (px_q < ex) ? (ex - px_q) : (px_q - ex);
        ady_q <= (py_q < ey) ? (ey - py_q) : (py_q - ey);
      end
      ST_SQX: sq_q <= rd_pkg::SQ_W'(prod);
      ST_SQY: sq_q <= sq_q + rd_pkg::SQ_W'(prod);
      ST_SQRT: if (sqrt_done) r_q <= root;
      ST_FT:  ft_q <= 16'(prod >> 2);
      ST_DIVP: begin
        if (div_done) begin
          quad_q <= phase[15:14];
          x15_q  <= phase[14] ? {15'(15'h4000 - {1'b0, phase[13:0]}), 1'b0}
                              : {1'b0, phase[13:0], 1'b0};
        end
      end
      ST_SN1: x2_q <= 16'(prod >> 15);
      ST_SN2: s_q  <= rd_pkg::SIN_B - 17'(prod >> 15);
      ST_SN3: s_q  <= rd_pkg::SIN_A - 17'(prod >> 15);
      ST_SN4: begin
        abs_s_q <= snv[15:0];
        neg_s_q <= quad_q[1] && (snv != 17'd0);
      end
      ST_DIVR: if (div_done) u_q <= 49'(quot);
      ST_DIVT: if (div_done) u_q <= u_q + 49'(quot);
      ST_E1: begin
        if (exp_zero) decay_q <= '0;
        n_q <= prod[36:32];
        f_q <= prod[31:16];
      end
      ST_E2: p_q <= rd_pkg::EXP_K2 - 17'(prod >> 16);
      ST_E3: p_q <= rd_pkg::EXP_K1 - 17'(prod >> 16);
      ST_E4: decay_q <= (17'h10000 - 17'(prod >> 16)) >> n_q;
      ST_SM: m_q  <= 17'(prod >> 16);
      ST_W1: am_q <= 32'(prod);
      ST_W2: w_q  <= 32'(prod >> 15);
      ST_CX: begin
        if (div_done) sum_x_q <= (neg_s_q ^ dxn_q) ? sum_x_q - cadd : sum_x_q + cadd;
      end
      ST_CY: begin
        if (div_done) sum_y_q <= (neg_s_q ^ dyn_q) ? sum_y_q - cadd : sum_y_q + cadd;
      end
      ST_FX: begin
        res_x_q <= sat_res[19:0];
        clip_q  <= clip_q | sat_res[20];
      end
      ST_FY: begin
        res_y_q <= sat_res[19:0];
        clip_q  <= clip_q | sat_res[20];
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(count_q) <= MAX_DROPS) && (int'(oldest_q) < MAX_DROPS))
    else $error("drop ring count or pointer out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_data_o.drops_held == 5'(count_q))
    else $error("drops_held does not match drop count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clipped) |->
      (out_data_o.disp_x == 20'h7FFFF || out_data_o.disp_x == 20'h80000 ||
       out_data_o.disp_y == 20'h7FFFF || out_data_o.disp_y == 20'h80000))
    else $error("clipped set without a saturated displacement");

endmodule

`default_nettype wire
